// File: rtl/core/mhti_pkg.sv
package mhti_pkg;

  // segment lengths
  localparam int HDR_LEN = 37;
  localparam int DHT_LEN = 420;
  localparam int IDX_W   = 9;
  localparam int HDR_DEPTH = 10;

  // marker bytes
  localparam logic [7:0] MK_FF   = 8'hff;
  localparam logic [7:0] MK_SOI  = 8'hd8;
  localparam logic [7:0] MK_APP0 = 8'he0;
  localparam logic [7:0] MK_DQT  = 8'hdb;

  // APP0 tags, first byte in the top bits
  localparam logic [31:0] TAG_JFIF = 32'h4a464946;
  localparam logic [31:0] TAG_AVI1 = 32'h41564931;

  localparam logic [7:0] BAD_LIMIT_RESET = 8'd50;

  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_DHT,
    SRC_MEM,
    SRC_CUR
  } src_t;

  typedef enum logic [1:0] {
    ST_GOOD       = 2'd0,
    ST_DROP_OK    = 2'd1,
    ST_DROP_LIMIT = 2'd2
  } status_t;

  // byte request from the sequencer
  typedef struct packed {
    logic             valid;
    logic             has_byte;
    src_t             src;
    logic [IDX_W-1:0] idx;
    logic [7:0]       cur;
    logic             is_end;
    logic             frame_last;
    status_t          status;
  } req_t;

  // resolved byte towards the packer
  typedef struct packed {
    logic       valid;
    logic       has_byte;
    logic [7:0] data;
    logic       is_end;
    logic       frame_last;
    status_t    status;
  } item_t;

  // header store write
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] data;
  } hdr_wr_t;

  localparam logic [7:0] HDR_SEG [0:HDR_LEN-1] = '{
    8'hff, 8'hd8, 8'hff, 8'he0, 8'h00, 8'h21, 8'h41, 8'h56,
    8'h49, 8'h31, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00, 8'h78,
    8'h00, 8'h78, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] DHT_SEG [0:DHT_LEN-1] = '{
    8'hff, 8'hc4, 8'h01, 8'ha2, 8'h00, 8'h00, 8'h01, 8'h05,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02,
    8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h01, 8'h00, 8'h03, 8'h01, 8'h01, 8'h01, 8'h01,
    8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
    8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h10, 8'h00,
    8'h02, 8'h01, 8'h03, 8'h03, 8'h02, 8'h04, 8'h03, 8'h05,
    8'h05, 8'h04, 8'h04, 8'h00, 8'h00, 8'h01, 8'h7d, 8'h01,
    8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21,
    8'h31, 8'h41, 8'h06, 8'h13, 8'h51, 8'h61, 8'h07, 8'h22,
    8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08, 8'h23,
    8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0, 8'h24,
    8'h33, 8'h62, 8'h72, 8'h82, 8'h09, 8'h0a, 8'h16, 8'h17,
    8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
    8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a,
    8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a,
    8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a,
    8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a,
    8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a,
    8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99,
    8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8,
    8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7,
    8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6,
    8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5,
    8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2, 8'he3,
    8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf1,
    8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9,
    8'hfa, 8'h11, 8'h00, 8'h02, 8'h01, 8'h02, 8'h04, 8'h04,
    8'h03, 8'h04, 8'h07, 8'h05, 8'h04, 8'h04, 8'h00, 8'h01,
    8'h02, 8'h77, 8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04,
    8'h05, 8'h21, 8'h31, 8'h06, 8'h12, 8'h41, 8'h51, 8'h07,
    8'h61, 8'h71, 8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14,
    8'h42, 8'h91, 8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33,
    8'h52, 8'hf0, 8'h15, 8'h62, 8'h72, 8'hd1, 8'h0a, 8'h16,
    8'h24, 8'h34, 8'he1, 8'h25, 8'hf1, 8'h17, 8'h18, 8'h19,
    8'h1a, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44, 8'h45, 8'h46,
    8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56,
    8'h57, 8'h58, 8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66,
    8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74, 8'h75, 8'h76,
    8'h77, 8'h78, 8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85,
    8'h86, 8'h87, 8'h88, 8'h89, 8'h8a, 8'h92, 8'h93, 8'h94,
    8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3,
    8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2,
    8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba,
    8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9,
    8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8,
    8'hd9, 8'hda, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7,
    8'he8, 8'he9, 8'hea, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
    8'hf7, 8'hf8, 8'hf9, 8'hfa
  };

endpackage

// File: rtl/core/mhti_if.sv
// input byte channel
interface mhti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

// packed result channel
interface mhti_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        run_last;
  logic        frame_done;
  logic [1:0]  frame_status;

  modport source (output valid, output out_bytes, output byte_count, output run_last,
                  output frame_done, output frame_status, input ready);
  modport sink   (input valid, input out_bytes, input byte_count, input run_last,
                  input frame_done, input frame_status, output ready);
endinterface

// File: rtl/core/mhti_ctrl.sv
module mhti_ctrl
  import mhti_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  mhti_in_if.sink  in_stream,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic     stall,
  output req_t     req,
  output hdr_wr_t  hdr_wr
);

  typedef enum logic [2:0] {
    K_CLASS, K_PASS, K_AVI, K_EMPTY, K_BAD
  } kind_t;

  // emission phases in output order; value i+1 matches enable bit i
  typedef enum logic [2:0] {
    P_IDLE  = 3'd0,
    P_HDR   = 3'd1,
    P_MEMA  = 3'd2,
    P_DHT   = 3'd3,
    P_MEMB  = 3'd4,
    P_CUR   = 3'd5,
    P_TAIL  = 3'd6,
    P_EMPTY = 3'd7
  } phase_t;

  localparam logic [5:0] EN_HDR  = 6'b000001;
  localparam logic [5:0] EN_MEMA = 6'b000010;
  localparam logic [5:0] EN_DHT  = 6'b000100;
  localparam logic [5:0] EN_MEMB = 6'b001000;
  localparam logic [5:0] EN_CUR  = 6'b010000;
  localparam logic [5:0] EN_TAIL = 6'b100000;

  function automatic phase_t next_after(phase_t p, logic [5:0] en);
    phase_t r;
    r = P_IDLE;
    for (int i = 5; i >= 0; i--) begin
      if (en[i] && (3'(i + 1) > p)) r = phase_t'(3'(i + 1));
    end
    return r;
  endfunction

  phase_t           phase;
  logic [IDX_W-1:0] cnt;
  logic [5:0]       plan_en;
  logic [3:0]       a_len, b_lo, b_hi;
  logic [7:0]       cur_b;
  logic             last_f;
  status_t          status_q;

  kind_t       kind;
  logic [23:0] byte_position;
  logic [16:0] insert_point;
  logic [7:0]  bad_run_count;
  logic [7:0]  bad_frame_limit;
  logic        sig_bad, jfif_ok, avi_ok;
  logic [15:0] app_len;

  logic             at_end, fin, active, accept;
  phase_t           nxt, first, start_ph;
  logic [IDX_W-1:0] nxt_cnt, start_cnt;

  logic [7:0]  b;
  logic [5:0]  p_en;
  logic [3:0]  p_a, p_blo, p_bhi;
  kind_t       kind_next;
  logic [16:0] ip_calc, insert_point_next;
  logic        bad_n;
  status_t     st;

  // sequencer progress
  always_comb begin
    unique case (phase)
      P_HDR:          at_end = (cnt == IDX_W'(HDR_LEN - 1));
      P_MEMA:         at_end = (cnt == {5'd0, a_len - 4'd1});
      P_DHT, P_TAIL:  at_end = (cnt == IDX_W'(DHT_LEN - 1));
      P_MEMB:         at_end = (cnt == {5'd0, b_hi});
      P_CUR, P_EMPTY: at_end = 1'b1;
      default:        at_end = 1'b0;
    endcase
  end

  assign nxt     = next_after(phase, plan_en);
  assign nxt_cnt = (nxt == P_MEMB) ? {5'd0, b_lo} : '0;
  assign fin     = (phase != P_IDLE) && at_end && (nxt == P_IDLE);
  assign active  = (phase != P_IDLE) && !stall;

  // the next byte is taken while the final request of this one issues
  assign in_stream.ready = (phase == P_IDLE) || (fin && !stall);
  assign accept = in_stream.valid && in_stream.ready;

  // byte request
  always_comb begin
    req.valid      = active;
    req.has_byte   = (phase != P_EMPTY);
    req.idx        = cnt;
    req.cur        = cur_b;
    req.is_end     = fin;
    req.frame_last = last_f;
    req.status     = status_q;
    unique case (phase)
      P_HDR:          req.src = SRC_HDR;
      P_DHT, P_TAIL:  req.src = SRC_DHT;
      P_MEMA, P_MEMB: req.src = SRC_MEM;
      default:        req.src = SRC_CUR;
    endcase
  end

  // plan for the incoming byte
  always_comb begin
    b                 = in_stream.data_byte;
    p_en              = '0;
    p_a               = '0;
    p_blo             = '0;
    p_bhi             = 4'(HDR_DEPTH - 1);
    kind_next         = kind;
    ip_calc           = 17'd4 + {1'b0, app_len};
    insert_point_next = insert_point;
    case (kind)
      K_CLASS: begin
        if (byte_position == 24'd2) begin
          if (sig_bad || b != MK_FF) kind_next = K_BAD;
        end else if (byte_position == 24'd3) begin
          if (b == MK_DQT) begin
            p_en      = EN_HDR | EN_DHT | EN_MEMB;
            p_blo     = 4'd2;
            p_bhi     = 4'd3;
            kind_next = K_PASS;
          end else if (b != MK_APP0) begin
            kind_next = K_EMPTY;
          end
        end else if (byte_position == 24'd9) begin
          if (jfif_ok && b == TAG_JFIF[7:0]) begin
            p_en      = EN_MEMB;
            kind_next = K_PASS;
          end else if (avi_ok && b == TAG_AVI1[7:0]) begin
            insert_point_next = ip_calc;
            if (ip_calc < 17'(HDR_DEPTH)) begin
              // table falls inside the buffered header
              p_en      = EN_MEMA | EN_DHT | EN_MEMB;
              p_a       = ip_calc[3:0];
              p_blo     = ip_calc[3:0];
              kind_next = K_PASS;
            end else begin
              p_en      = EN_MEMB;
              kind_next = K_AVI;
            end
          end else begin
            kind_next = K_BAD;
          end
        end
      end
      K_PASS: p_en = EN_CUR;
      K_AVI: begin
        if (byte_position == {7'd0, insert_point}) begin
          p_en      = EN_DHT | EN_CUR;
          kind_next = K_PASS;
        end else begin
          p_en = EN_CUR;
        end
      end
      default: ;
    endcase
    // frame ended before the insertion point
    if (in_stream.frame_last && kind_next == K_AVI) p_en = p_en | EN_TAIL;

    bad_n = in_stream.frame_last && (kind_next == K_CLASS || kind_next == K_BAD);
    if (bad_n) st = (bad_run_count < bad_frame_limit) ? ST_DROP_OK : ST_DROP_LIMIT;
    else       st = ST_GOOD;

    first = next_after(P_IDLE, p_en);
    if (first != P_IDLE)            start_ph = first;
    else if (in_stream.frame_last)  start_ph = P_EMPTY;
    else                            start_ph = P_IDLE;
    start_cnt = (first == P_MEMB) ? {5'd0, p_blo} : '0;
  end

  // header store write
  assign hdr_wr.en   = accept && (byte_position < 24'(HDR_DEPTH));
  assign hdr_wr.addr = byte_position[3:0];
  assign hdr_wr.data = in_stream.data_byte;

  // state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= P_IDLE;
      cnt             <= '0;
      plan_en         <= '0;
      kind            <= K_CLASS;
      byte_position   <= '0;
      insert_point    <= '0;
      bad_run_count   <= '0;
      bad_frame_limit <= BAD_LIMIT_RESET;
    end else begin
      if (cfg_we) bad_frame_limit <= cfg_wdata;
      if (accept) begin
        phase        <= start_ph;
        cnt          <= start_cnt;
        plan_en      <= p_en;
        a_len        <= p_a;
        b_lo         <= p_blo;
        b_hi         <= p_bhi;
        cur_b        <= b;
        last_f       <= in_stream.frame_last;
        status_q     <= st;
        insert_point <= insert_point_next;
        // running header checks
        unique case (byte_position)
          24'd0: sig_bad <= (b != MK_FF);
          24'd1: sig_bad <= sig_bad | (b != MK_SOI);
          24'd4: app_len[15:8] <= b;
          24'd5: app_len[7:0] <= b;
          24'd6: begin
            jfif_ok <= (b == TAG_JFIF[31:24]);
            avi_ok  <= (b == TAG_AVI1[31:24]);
          end
          24'd7: begin
            jfif_ok <= jfif_ok & (b == TAG_JFIF[23:16]);
            avi_ok  <= avi_ok & (b == TAG_AVI1[23:16]);
          end
          24'd8: begin
            jfif_ok <= jfif_ok & (b == TAG_JFIF[15:8]);
            avi_ok  <= avi_ok & (b == TAG_AVI1[15:8]);
          end
          default: ;
        endcase
        if (in_stream.frame_last) begin
          kind          <= K_CLASS;
          byte_position <= '0;
          if (bad_n) begin
            if (bad_run_count != 8'hff) bad_run_count <= bad_run_count + 8'd1;
          end else begin
            bad_run_count <= '0;
          end
        end else begin
          kind <= kind_next;
          if (byte_position != 24'hffffff) byte_position <= byte_position + 24'd1;
        end
      end else if (active) begin
        if (at_end) begin
          phase <= nxt;
          cnt   <= nxt_cnt;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/mhti_fetch.sv
module mhti_fetch
  import mhti_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    stall,
  input  req_t    req,
  input  hdr_wr_t hdr_wr,
  output item_t   item
);

  logic [7:0] hdr_mem [0:HDR_DEPTH-1];
  logic [7:0] rd_q, rom_q, cur_q;
  src_t       src_q;
  logic       f_valid, has_q, end_q, last_q;
  status_t    st_q;

  // header store; a read and a write in the same cycle return the old entry,
  // which is what a finishing step wants while the next byte is written
  always_ff @(posedge clk) begin
    if (hdr_wr.en) hdr_mem[hdr_wr.addr] <= hdr_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!stall) begin
      f_valid <= req.valid;
    end
  end

  // registered memory and table reads
  always_ff @(posedge clk) begin
    if (!stall) begin
      rd_q   <= hdr_mem[req.idx[3:0]];
      rom_q  <= (req.src == SRC_DHT) ? DHT_SEG[req.idx] : HDR_SEG[req.idx[5:0]];
      cur_q  <= req.cur;
      src_q  <= req.src;
      has_q  <= req.has_byte;
      end_q  <= req.is_end;
      last_q <= req.frame_last;
      st_q   <= req.status;
    end
  end

  always_comb begin
    item.valid      = f_valid;
    item.has_byte   = has_q;
    item.is_end     = end_q;
    item.frame_last = last_q;
    item.status     = st_q;
    unique case (src_q)
      SRC_MEM:          item.data = rd_q;
      SRC_CUR:          item.data = cur_q;
      SRC_HDR, SRC_DHT: item.data = rom_q;
      default:          item.data = rom_q;
    endcase
  end

endmodule

// File: rtl/core/mhti_pack.sv
module mhti_pack
  import mhti_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  mhti_out_if.source out_stream,
  output logic       stall
);

  logic [63:0] acc, word_n;
  logic [3:0]  cnt, cnt_n;
  logic        take, push, done;

  assign stall  = out_stream.valid && !out_stream.ready;
  assign take   = item.valid && !stall;
  assign word_n = acc | (64'(item.data) << {cnt[2:0], 3'b000});
  assign cnt_n  = cnt + 4'd1;
  assign done   = item.is_end && item.frame_last;

  // a result leaves on the eighth byte or at the end of the step
  always_comb begin
    if (item.has_byte) push = take && (cnt_n == 4'd8 || item.is_end);
    else               push = take && item.frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stream.valid <= 1'b0;
      acc              <= '0;
      cnt              <= '0;
    end else begin
      if (push)                  out_stream.valid <= 1'b1;
      else if (out_stream.ready) out_stream.valid <= 1'b0;
      if (push) begin
        acc <= '0;
        cnt <= '0;
      end else if (take && item.has_byte) begin
        acc <= word_n;
        cnt <= cnt_n;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (push) begin
      out_stream.out_bytes    <= item.has_byte ? word_n : acc;
      out_stream.byte_count   <= item.has_byte ? cnt_n : cnt;
      out_stream.run_last     <= item.is_end;
      out_stream.frame_done   <= done;
      out_stream.frame_status <= done ? item.status : ST_GOOD;
    end
  end

`ifndef NO_ASSERTIONS
  a_acc_not_full: assert property (@(posedge clk) disable iff (rst) cnt != 4'd8)
    else $error("packer holds a full word");
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_stream.valid && out_stream.frame_status != ST_GOOD) |-> out_stream.frame_done)
    else $error("drop status outside frame end");
  a_empty_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_stream.valid && out_stream.byte_count == 4'd0) |-> out_stream.frame_done)
    else $error("empty result not closing a frame");
  a_push_shows: assert property (@(posedge clk) disable iff (rst) push |=> out_stream.valid)
    else $error("pushed result not presented");
`endif

endmodule

// File: rtl/core/mjpeg_huffman_table_inserter.sv
// MJPEG Huffman table inserter. Camera frames enter one byte per transfer, with
// frame_last on the final byte; results leave packed up to eight bytes each,
// first byte in bits 7..0. JFIF frames pass unchanged, AVI1 frames get the
// standard 420-byte DHT segment at 4 plus the APP0 length (appended at the end
// if the frame is shorter), frames starting with a DQT get a 37-byte AVI1
// header and the table in place of their first two bytes, other frames come
// out empty, and frames with a bad marker or tag are dropped and counted
// against bad_frame_limit. The first ten bytes sit in a small header memory
// with a registered read. The emitter produces one output byte per cycle while
// no result stalls: pass-through bytes run at one per cycle, while the byte
// that triggers a table insertion (AVI1 or DQT start) lets no new byte in
// until its last output byte issues. A stalled result holds the whole
// emitter.
module mjpeg_huffman_table_inserter
  import mhti_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mhti_in_if.sink    in_stream,
  mhti_out_if.source out_stream,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  req_t    req;
  hdr_wr_t hdr_wr;
  item_t   item;
  logic    stall;

  mhti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_stream),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stall     (stall),
    .req       (req),
    .hdr_wr    (hdr_wr)
  );

  mhti_fetch u_fetch (
    .clk    (clk),
    .rst    (rst),
    .stall  (stall),
    .req    (req),
    .hdr_wr (hdr_wr),
    .item   (item)
  );

  mhti_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .out_stream (out_stream),
    .stall      (stall)
  );

endmodule
